>>> rtl/asb_pkg.sv
// Shared types and constants of the affine bilinear sampler.
package asb_pkg;

   localparam int SRC_BITS   = 8;
   localparam int DEST_BITS  = 10;
   localparam int COORD_W    = 32;
   localparam int SIZE_W     = SRC_BITS + 1;
   localparam int FRAC_BITS  = 12;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = CHAN_W * NUM_CHAN;
   localparam int BANK_AW    = 2 * (SRC_BITS - 1);
   localparam int NUM_BANKS  = 4;
   localparam int WEIGHT_W   = FRAC_BITS + 1;
   localparam int TOP_W      = CHAN_W + FRAC_BITS;
   localparam int SUM_W      = CHAN_W + 2 * FRAC_BITS;
   localparam int CSR_IDX_W  = 3;
   localparam logic [SIZE_W-1:0] MAX_SIDE = SIZE_W'(1 << SRC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X  = 3'd0,
      CSR_START_Y  = 3'd1,
      CSR_STEP_UX  = 3'd2,
      CSR_STEP_UY  = 3'd3,
      CSR_STEP_VX  = 3'd4,
      CSR_STEP_VY  = 3'd5,
      CSR_SRC_W    = 3'd6,
      CSR_SRC_H    = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef struct packed {
      logic                               load_valid;
      logic                               sample_valid;
      logic                               outside;
      logic [1:0]                         load_bank;
      logic [BANK_AW-1:0]                 load_addr;
      logic [PIX_W-1:0]                   load_pix;
      logic [NUM_BANKS-1:0][BANK_AW-1:0]  rd_addr;
      logic                               x0_odd;
      logic                               x1_odd;
      logic                               y0_odd;
      logic                               y1_odd;
      logic [FRAC_BITS-1:0]               frac_x;
      logic [FRAC_BITS-1:0]               frac_y;
   } fetch_type;

   typedef struct packed {
      logic                 valid;
      logic                 outside;
      logic                 x0_odd;
      logic                 x1_odd;
      logic                 y0_odd;
      logic                 y1_odd;
      logic [FRAC_BITS-1:0] frac_x;
      logic [FRAC_BITS-1:0] frac_y;
   } blend_ctl_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) r = SIZE_W'(1);
      else if (s > MAX_SIDE) r = MAX_SIDE;
      return r;
   endfunction

endpackage

>>> rtl/asb_map.sv
// Coordinate mapping: products, position sums, range check and tap addresses.
module asb_map
   import asb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic                  in_cmd,
   input  logic [DEST_BITS-1:0]  in_u,
   input  logic [DEST_BITS-1:0]  in_v,
   input  logic [SRC_BITS-1:0]   in_col,
   input  logic [SRC_BITS-1:0]   in_row,
   input  logic [PIX_W-1:0]      in_pix,
   input  logic [COORD_W-1:0]    start_x,
   input  logic [COORD_W-1:0]    start_y,
   input  logic [COORD_W-1:0]    step_ux,
   input  logic [COORD_W-1:0]    step_uy,
   input  logic [COORD_W-1:0]    step_vx,
   input  logic [COORD_W-1:0]    step_vy,
   input  logic [SIZE_W-1:0]     src_w,
   input  logic [SIZE_W-1:0]     src_h,
   output fetch_type             fetch
);

   logic                 a_valid_ff, a_sample_ff;
   logic [COORD_W-1:0]   a_ux_ff, a_uy_ff, a_vx_ff, a_vy_ff;
   logic [SRC_BITS-1:0]  a_col_ff, a_row_ff;
   logic [PIX_W-1:0]     a_pix_ff;

   logic                 b_valid_ff, b_sample_ff;
   logic [COORD_W-1:0]   b_px_ff, b_py_ff;
   logic [SRC_BITS-1:0]  b_col_ff, b_row_ff;
   logic [PIX_W-1:0]     b_pix_ff;

   fetch_type            fetch_ff, fetch_in;

   logic [SIZE_W-1:0]    w_eff, h_eff;
   logic [SRC_BITS-1:0]  x0, x1, y0, y1;
   logic                 out_x, out_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sample_ff <= (in_cmd == CMD_SAMPLE);
         a_ux_ff     <= COORD_W'(COORD_W'(in_u) * step_ux);
         a_uy_ff     <= COORD_W'(COORD_W'(in_u) * step_uy);
         a_vx_ff     <= COORD_W'(COORD_W'(in_v) * step_vx);
         a_vy_ff     <= COORD_W'(COORD_W'(in_v) * step_vy);
         a_col_ff    <= in_col;
         a_row_ff    <= in_row;
         a_pix_ff    <= in_pix;
         b_sample_ff <= a_sample_ff;
         b_px_ff     <= start_x + a_ux_ff + a_vx_ff;
         b_py_ff     <= start_y + a_uy_ff + a_vy_ff;
         b_col_ff    <= a_col_ff;
         b_row_ff    <= a_row_ff;
         b_pix_ff    <= a_pix_ff;
      end
   end

   asb_axis u_axis_x (
      .pos     (b_px_ff),
      .size    (w_eff),
      .outside (out_x),
      .tap0    (x0),
      .tap1    (x1)
   );

   asb_axis u_axis_y (
      .pos     (b_py_ff),
      .size    (h_eff),
      .outside (out_y),
      .tap0    (y0),
      .tap1    (y1)
   );

   always_comb begin
      w_eff = eff_size(src_w);
      h_eff = eff_size(src_h);
      fetch_in.load_valid   = b_valid_ff && !b_sample_ff;
      fetch_in.sample_valid = b_valid_ff && b_sample_ff;
      fetch_in.outside      = out_x || out_y;
      fetch_in.load_bank    = {b_row_ff[0], b_col_ff[0]};
      fetch_in.load_addr    = {b_row_ff[SRC_BITS-1:1], b_col_ff[SRC_BITS-1:1]};
      fetch_in.load_pix     = b_pix_ff;
      for (int b = 0; b < NUM_BANKS; b++) begin
         fetch_in.rd_addr[b] = {
            ((y0[0] == b[1]) ? y0[SRC_BITS-1:1] : y1[SRC_BITS-1:1]),
            ((x0[0] == b[0]) ? x0[SRC_BITS-1:1] : x1[SRC_BITS-1:1])};
      end
      fetch_in.x0_odd = x0[0];
      fetch_in.x1_odd = x1[0];
      fetch_in.y0_odd = y0[0];
      fetch_in.y1_odd = y1[0];
      fetch_in.frac_x = b_px_ff[FRAC_BITS-1:0];
      fetch_in.frac_y = b_py_ff[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff <= '0;
      end else if (adv) begin
         fetch_ff <= fetch_in;
      end
   end

   assign fetch = fetch_ff;

endmodule

>>> rtl/asb_axis.sv
// One axis of the position check: half-pixel border test and clamped tap pair.
module asb_axis
   import asb_pkg::*;
(
   input  logic [COORD_W-1:0]   pos,
   input  logic [SIZE_W-1:0]    size,
   output logic                 outside,
   output logic [SRC_BITS-1:0]  tap0,
   output logic [SRC_BITS-1:0]  tap1
);

   localparam int EXT_W = COORD_W + 2;
   localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1 << (FRAC_BITS - 1));

   logic signed [EXT_W-1:0] pos_ext, limit;
   logic [SRC_BITS-1:0]     ip;

   always_comb begin
      pos_ext = EXT_W'($signed(pos));
      limit   = $signed({{(EXT_W-SIZE_W-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}}) - HALF;
      outside = (pos_ext < -HALF) || (pos_ext >= limit);
      ip      = pos[FRAC_BITS+SRC_BITS-1:FRAC_BITS];
      if (pos[COORD_W-1]) begin
         tap0 = '0;
         tap1 = '0;
      end else if ({1'b0, ip} >= size - SIZE_W'(1)) begin
         tap0 = ip;
         tap1 = ip;
      end else begin
         tap0 = ip;
         tap1 = ip + SRC_BITS'(1);
      end
   end

endmodule

>>> rtl/asb_store.sv
// Four-bank source pixel memory, banked by row and column parity.
module asb_store
   import asb_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  fetch_type                         fetch,
   output logic [NUM_BANKS-1:0][PIX_W-1:0]   rd_pix,
   output blend_ctl_type                     ctl
);

   localparam int BANK_DEPTH = 1 << BANK_AW;

   blend_ctl_type                   ctl_ff;

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      logic [PIX_W-1:0] mem [BANK_DEPTH];
      logic [PIX_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (adv) begin
            if (fetch.load_valid && (fetch.load_bank == 2'(g))) begin
               mem[fetch.load_addr] <= fetch.load_pix;
            end
            rd_ff <= mem[fetch.rd_addr[g]];
         end
      end

      assign rd_pix[g] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid   <= fetch.sample_valid;
         ctl_ff.outside <= fetch.outside;
         ctl_ff.x0_odd  <= fetch.x0_odd;
         ctl_ff.x1_odd  <= fetch.x1_odd;
         ctl_ff.y0_odd  <= fetch.y0_odd;
         ctl_ff.y1_odd  <= fetch.y1_odd;
         ctl_ff.frac_x  <= fetch.frac_x;
         ctl_ff.frac_y  <= fetch.frac_y;
      end
   end

   assign ctl    = ctl_ff;

endmodule

>>> rtl/asb_blend.sv
// Bilinear blend: horizontal weighting, vertical weighting and result register.
module asb_blend
   import asb_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [NUM_BANKS-1:0][PIX_W-1:0]   rd_pix,
   input  blend_ctl_type                     ctl,
   output logic                              out_valid,
   output logic [NUM_CHAN-1:0][CHAN_W-1:0]   out_chan,
   output logic                              out_flag
);

   localparam logic [WEIGHT_W-1:0] ONE = WEIGHT_W'(1 << FRAC_BITS);

   logic [PIX_W-1:0]                p00, p01, p10, p11;
   logic [WEIGHT_W-1:0]             ox, fx;
   logic [NUM_CHAN-1:0][TOP_W-1:0]  top_in, bot_in;

   logic                            h_valid_ff, h_out_ff;
   logic [NUM_CHAN-1:0][TOP_W-1:0]  top_ff, bot_ff;
   logic [FRAC_BITS-1:0]            h_fy_ff;
   logic [WEIGHT_W-1:0]             oy, fy;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_in;
   logic [SUM_W-1:0]                sum;

   logic                            o_valid_ff, o_flag_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] o_chan_ff;

   always_comb begin
      p00 = rd_pix[{ctl.y0_odd, ctl.x0_odd}];
      p01 = rd_pix[{ctl.y0_odd, ctl.x1_odd}];
      p10 = rd_pix[{ctl.y1_odd, ctl.x0_odd}];
      p11 = rd_pix[{ctl.y1_odd, ctl.x1_odd}];
      fx  = WEIGHT_W'(ctl.frac_x);
      ox  = ONE - fx;
      for (int c = 0; c < NUM_CHAN; c++) begin
         top_in[c] = TOP_W'(TOP_W'(p00[c*CHAN_W +: CHAN_W]) * TOP_W'(ox))
                   + TOP_W'(TOP_W'(p01[c*CHAN_W +: CHAN_W]) * TOP_W'(fx));
         bot_in[c] = TOP_W'(TOP_W'(p10[c*CHAN_W +: CHAN_W]) * TOP_W'(ox))
                   + TOP_W'(TOP_W'(p11[c*CHAN_W +: CHAN_W]) * TOP_W'(fx));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= ctl.valid;
         o_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_out_ff  <= ctl.outside;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         h_fy_ff   <= ctl.frac_y;
         o_flag_ff <= h_out_ff;
         o_chan_ff <= chan_in;
      end
   end

   always_comb begin
      fy  = WEIGHT_W'(h_fy_ff);
      oy  = ONE - fy;
      sum = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum = SUM_W'(SUM_W'(top_ff[c]) * SUM_W'(oy))
             + SUM_W'(SUM_W'(bot_ff[c]) * SUM_W'(fy));
         chan_in[c] = h_out_ff ? '0 : sum[SUM_W-1 -: CHAN_W];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_chan  = o_chan_ff;
   assign out_flag  = o_flag_ff;

endmodule

>>> rtl/affine_bilinear_sampler.sv
// Affine bilinear sampler: register file, pipeline control and stage wiring.
//
// Usage: the request channel carries load and sample transactions. A load
// writes one pixel into the source store and returns nothing; a sample
// returns one response with three interpolated channels and the outside
// flag. Responses come in request order.
// A sample transaction passes the stages multiply, position sum, tap check,
// memory read, horizontal blend, and vertical blend into the result
// register. Throughput: one transaction per cycle while req_stall is low;
// the four neighbours are read together from four banks split by row and
// column parity, each with one port.
// Stall: the pipeline advances as a whole whenever the response register is
// empty or being taken; while rsp_stall holds a waiting response, req_stall
// is raised and every stage holds its contents, so nothing is lost or
// repeated.
// Reset clears all valid bits and loads the register defaults. The pixel
// store is not cleared; pixels must be loaded before they are sampled.
// The user writes registers via the csr port only while idle; not enforced.
module affine_bilinear_sampler
   import asb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [DEST_BITS-1:0]  req_dest_col,
   input  logic [DEST_BITS-1:0]  req_dest_row,
   input  logic [SRC_BITS-1:0]   req_src_col,
   input  logic [SRC_BITS-1:0]   req_src_row,
   input  logic [CHAN_W-1:0]     req_load_chan0,
   input  logic [CHAN_W-1:0]     req_load_chan1,
   input  logic [CHAN_W-1:0]     req_load_chan2,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_out_chan0,
   output logic [CHAN_W-1:0]     rsp_out_chan1,
   output logic [CHAN_W-1:0]     rsp_out_chan2,
   output logic                  rsp_outside_source,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_W-1:0]    csr_data
);

   logic [COORD_W-1:0] start_x_ff, start_y_ff;
   logic [COORD_W-1:0] step_ux_ff, step_uy_ff, step_vx_ff, step_vy_ff;
   logic [SIZE_W-1:0]  src_w_ff, src_h_ff;

   logic                              adv;
   fetch_type                         fetch;
   logic [NUM_BANKS-1:0][PIX_W-1:0]   rd_pix;
   blend_ctl_type                     ctl;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   out_chan;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         step_ux_ff <= COORD_W'(1 << FRAC_BITS);
         step_uy_ff <= '0;
         step_vx_ff <= '0;
         step_vy_ff <= COORD_W'(1 << FRAC_BITS);
         src_w_ff   <= SIZE_W'(1);
         src_h_ff   <= SIZE_W'(1);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_X: start_x_ff <= csr_data;
            CSR_START_Y: start_y_ff <= csr_data;
            CSR_STEP_UX: step_ux_ff <= csr_data;
            CSR_STEP_UY: step_uy_ff <= csr_data;
            CSR_STEP_VX: step_vx_ff <= csr_data;
            CSR_STEP_VY: step_vy_ff <= csr_data;
            CSR_SRC_W:   src_w_ff   <= csr_data[SIZE_W-1:0];
            CSR_SRC_H:   src_h_ff   <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   asb_map u_map (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_cmd   (req_command),
      .in_u     (req_dest_col),
      .in_v     (req_dest_row),
      .in_col   (req_src_col),
      .in_row   (req_src_row),
      .in_pix   ({req_load_chan2, req_load_chan1, req_load_chan0}),
      .start_x  (start_x_ff),
      .start_y  (start_y_ff),
      .step_ux  (step_ux_ff),
      .step_uy  (step_uy_ff),
      .step_vx  (step_vx_ff),
      .step_vy  (step_vy_ff),
      .src_w    (src_w_ff),
      .src_h    (src_h_ff),
      .fetch    (fetch)
   );

   asb_store u_store (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .fetch  (fetch),
      .rd_pix (rd_pix),
      .ctl    (ctl)
   );

   asb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .rd_pix    (rd_pix),
      .ctl       (ctl),
      .out_valid (rsp_valid),
      .out_chan  (out_chan),
      .out_flag  (rsp_outside_source)
   );

   assign rsp_out_chan0 = out_chan[0];
   assign rsp_out_chan1 = out_chan[1];
   assign rsp_out_chan2 = out_chan[2];

endmodule
